>>> rtl/core/assert_macros.svh
// assertion macros shared by the date block rtl
// expects clk and arst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gda_pkg.sv
// types, constants and month table for the date add-days block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

	localparam int YEAR_BITS    = 16;
	localparam int DAY_W        = 5;
	localparam int MONTH_W      = 4;
	localparam int YEAR_FIELD_W = 16;
	localparam int DELTA_W      = 16;
	// day accumulator holds day plus a signed delta
	localparam int DACC_W       = DELTA_W + 1;
	localparam int ALU_W        = ((YEAR_BITS > DACC_W) ? YEAR_BITS : DACC_W) + 1;

	localparam int YEAR_MOD     = 400;
	localparam int CENTURY      = 100;
	// odd factor shared by 100 and 400
	localparam int LEAP_ODD     = 25;

	localparam int RESET_DAY    = 1;
	localparam int RESET_MONTH  = 1;
	localparam int RESET_YEAR   = 2000;
	localparam int JAN          = 1;
	localparam int FEB          = 2;
	localparam int DEC          = 12;
	localparam int DEC_DAYS     = 31;

	typedef logic [DAY_W-1:0]          day_t;
	typedef logic [MONTH_W-1:0]        month_t;
	typedef logic [YEAR_BITS-1:0]      year_t;
	typedef logic signed [DACC_W-1:0]  dacc_t;
	typedef logic [ALU_W-1:0]          alu_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FWD,
		ST_BWD,
		ST_DONE
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t   op;
		alu_word_t a;
		alu_word_t b;
	} alu_req_t;

	typedef struct packed {
		alu_word_t sum;
		logic      neg;
		logic      zero;
	} alu_rsp_t;

	// inverse of an odd number modulo 2^64, each newton step doubles the good bits
	function automatic longint odd_inverse(input longint d);
		longint x;
		x = d;
		for (int i = 0; i < 5; i++)
			x = x * (longint'(2) - d * x);
		return x;
	endfunction

	localparam longint YEAR_MASK = (longint'(1) << YEAR_BITS) - 1;
	localparam year_t  INV_ODD   = year_t'(odd_inverse(longint'(LEAP_ODD)) & YEAR_MASK);
	// a year is a multiple of 25 exactly when year * INV_ODD wraps to at most this
	localparam year_t  ODD_MAX   = year_t'(YEAR_MASK / LEAP_ODD);

	// days in a month, february stretched in leap years
	function automatic day_t month_days(input month_t m, input logic leap);
		day_t len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = day_t'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = day_t'(30);
			4'd2:                                        len = leap ? day_t'(29) : day_t'(28);
			default:                                     len = day_t'(31);
		endcase
		return len;
	endfunction

	// leap: multiple of 4, and of 16 too when it is a multiple of 25
	function automatic logic is_leap(input year_t y);
		year_t wrap;
		logic  odd_div;
		wrap    = y * INV_ODD;
		odd_div = (wrap <= ODD_MAX);
		return (y[1:0] == 2'b00) && (!odd_div || (y[3:0] == 4'b0000));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/gda_alu.sv
// shared add/subtract unit for the date sequencer
// depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none

module gda_alu (
	input  gda_pkg::alu_req_t req,
	output gda_pkg::alu_rsp_t rsp
);

	gda_pkg::alu_word_t sum;

	always_comb begin
		unique case (req.op)
			gda_pkg::ALU_ADD: sum = req.a + req.b;
			gda_pkg::ALU_SUB: sum = req.a - req.b;
			default:          sum = req.a + req.b;
		endcase
	end

	assign rsp.sum  = sum;
	assign rsp.neg  = sum[gda_pkg::ALU_W-1];
	assign rsp.zero = (sum == '0);

endmodule

`default_nettype wire

>>> rtl/core/gregorian_date_add_days.sv
// gregorian date register with set and add-days beats
// set: checked and loaded on accept, published from the done state, then back to idle
// add: sum on accept, a step per month crossed (forward, then back if needed), settle, publish
// done waits while the output register still holds an unaccepted result
// one beat in flight: req_stall is high from accept until the result is in the output register
// reset (arst_n low, async) clears the date to 1.1.2000 and drops rsp_valid
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gregorian_date_add_days (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic        func,
	input  logic [4:0]  new_day,
	input  logic [3:0]  new_month,
	input  logic [15:0] new_year,
	input  logic signed [15:0] day_delta,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [4:0]  cur_day,
	output logic [3:0]  cur_month,
	output logic [15:0] cur_year,
	output logic        set_invalid,
	output logic        year_saturated
);

	// sequencer state
	gda_pkg::state_t    state_q;
	gda_pkg::state_t    state_nxt;

	// held date; the leap test works straight from the year
	gda_pkg::day_t      day_q;
	gda_pkg::month_t    month_q;
	gda_pkg::year_t     year_q;

	// working registers of one beat
	gda_pkg::dacc_t     d_q;       // running day count, may go far outside 1..31
	logic               inval_q;
	logic               sat_q;

	// output register, parts the result side from the sequencer
	logic               rsp_valid_q;
	gda_pkg::day_t      cur_day_q;
	gda_pkg::month_t    cur_month_q;
	logic [15:0]        cur_year_q;
	logic               set_invalid_q;
	logic               year_saturated_q;

	gda_pkg::alu_req_t  alu_req;
	gda_pkg::alu_rsp_t  alu_rsp;

	logic               req_accept;
	logic               set_ok;
	logic               leap;
	gda_pkg::day_t      len_fwd;
	gda_pkg::month_t    prev_month;
	gda_pkg::day_t      len_bwd;
	logic               fwd_step;
	logic               d_le0;
	logic               year_top;
	logic               at_jan;
	logic               at_dec;
	logic               publish;

	// the one arithmetic unit, reused by the idle, forward and backward states
	gda_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign req_accept = req_valid && (state_q == gda_pkg::ST_IDLE);
	assign req_stall  = (state_q != gda_pkg::ST_IDLE);

	// set check uses the plain table, so february 29 is refused
	assign set_ok = (new_month >= gda_pkg::month_t'(gda_pkg::JAN)) &&
		(new_month <= gda_pkg::month_t'(gda_pkg::DEC)) &&
		(new_day != '0) &&
		(new_day <= gda_pkg::month_days(new_month, 1'b0));

	assign leap       = gda_pkg::is_leap(year_q);
	assign at_jan     = (month_q == gda_pkg::month_t'(gda_pkg::JAN));
	assign at_dec     = (month_q == gda_pkg::month_t'(gda_pkg::DEC));
	assign len_fwd    = gda_pkg::month_days(month_q, leap);
	// going back adds the length of the month being entered; december ignores leap
	assign prev_month = at_jan ? gda_pkg::month_t'(gda_pkg::DEC) : (month_q - 4'd1);
	assign len_bwd    = gda_pkg::month_days(prev_month, leap);

	assign fwd_step = !alu_rsp.neg && !alu_rsp.zero;   // d > month length
	assign d_le0    = d_q[gda_pkg::DACC_W-1] || (d_q == '0);
	assign year_top = (year_q == '1);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (req_accept) begin
					if (func)
						state_nxt = gda_pkg::ST_FWD;
					else
						state_nxt = gda_pkg::ST_DONE;
				end
			end
			gda_pkg::ST_FWD: begin
				priority if (fwd_step && at_dec && year_top)
					state_nxt = gda_pkg::ST_DONE;
				else if (fwd_step)
					state_nxt = gda_pkg::ST_FWD;
				else if (d_le0)
					state_nxt = gda_pkg::ST_BWD;
				else
					state_nxt = gda_pkg::ST_DONE;
			end
			gda_pkg::ST_BWD: begin
				priority if (d_le0 && at_jan && (year_q == '0))
					state_nxt = gda_pkg::ST_DONE;
				else if (d_le0)
					state_nxt = gda_pkg::ST_BWD;
				else
					state_nxt = gda_pkg::ST_DONE;
			end
			gda_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall)
					state_nxt = gda_pkg::ST_IDLE;
			end
			default: state_nxt = gda_pkg::ST_IDLE;
		endcase
	end

	// adder operands and publish strobe per state
	always_comb begin
		alu_req.op = gda_pkg::ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		publish    = 1'b0;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				// day plus signed delta
				alu_req.op = gda_pkg::ALU_ADD;
				alu_req.a  = gda_pkg::ALU_W'(day_q);
				alu_req.b  = gda_pkg::ALU_W'(day_delta);
			end
			gda_pkg::ST_FWD: begin
				alu_req.op = gda_pkg::ALU_SUB;
				alu_req.a  = gda_pkg::ALU_W'(d_q);
				alu_req.b  = gda_pkg::ALU_W'(len_fwd);
			end
			gda_pkg::ST_BWD: begin
				alu_req.op = gda_pkg::ALU_ADD;
				alu_req.a  = gda_pkg::ALU_W'(d_q);
				alu_req.b  = gda_pkg::ALU_W'(len_bwd);
			end
			gda_pkg::ST_DONE: begin
				publish = !rsp_valid_q || !rsp_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gda_pkg::ST_IDLE;
			day_q       <= gda_pkg::day_t'(gda_pkg::RESET_DAY);
			month_q     <= gda_pkg::month_t'(gda_pkg::RESET_MONTH);
			year_q      <= gda_pkg::year_t'(gda_pkg::RESET_YEAR);
			d_q         <= gda_pkg::dacc_t'(gda_pkg::RESET_DAY);
			inval_q     <= 1'b0;
			sat_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// output register fills on publish and empties when taken
			if (publish)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				gda_pkg::ST_IDLE: begin
					if (req_accept) begin
						inval_q <= !func && !set_ok;
						sat_q   <= 1'b0;
						if (func) begin
							d_q <= alu_rsp.sum[gda_pkg::DACC_W-1:0];
						end else if (set_ok) begin
							d_q     <= gda_pkg::dacc_t'(new_day);
							month_q <= new_month;
							year_q  <= gda_pkg::year_t'(new_year);
						end else begin
							// rejected set falls back to the reset date
							d_q     <= gda_pkg::dacc_t'(gda_pkg::RESET_DAY);
							month_q <= gda_pkg::month_t'(gda_pkg::RESET_MONTH);
							year_q  <= gda_pkg::year_t'(gda_pkg::RESET_YEAR);
						end
					end
				end
				gda_pkg::ST_FWD: begin
					if (fwd_step) begin
						if (at_dec && year_top) begin
							// pinned at the last day of the top year
							d_q   <= gda_pkg::dacc_t'(gda_pkg::DEC_DAYS);
							sat_q <= 1'b1;
						end else begin
							d_q <= alu_rsp.sum[gda_pkg::DACC_W-1:0];
							if (at_dec) begin
								month_q <= gda_pkg::month_t'(gda_pkg::JAN);
								year_q  <= year_q + gda_pkg::year_t'(1);
							end else begin
								month_q <= month_q + 4'd1;
							end
						end
					end
				end
				gda_pkg::ST_BWD: begin
					if (d_le0) begin
						if (at_jan && (year_q == '0)) begin
							// pinned at the first day of year zero
							d_q   <= gda_pkg::dacc_t'(gda_pkg::RESET_DAY);
							sat_q <= 1'b1;
						end else begin
							d_q     <= alu_rsp.sum[gda_pkg::DACC_W-1:0];
							month_q <= prev_month;
							if (at_jan)
								year_q <= year_q - gda_pkg::year_t'(1);
						end
					end
				end
				gda_pkg::ST_DONE: begin
					if (publish)
						day_q <= d_q[gda_pkg::DAY_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// result beat payload, loaded only when the output register is free
	always_ff @(posedge clk) begin
		if (publish) begin
			cur_day_q        <= d_q[gda_pkg::DAY_W-1:0];
			cur_month_q      <= month_q;
			cur_year_q       <= 16'(year_q);
			set_invalid_q    <= inval_q;
			year_saturated_q <= sat_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign cur_day        = cur_day_q;
	assign cur_month      = cur_month_q;
	assign cur_year       = cur_year_q;
	assign set_invalid    = set_invalid_q;
	assign year_saturated = year_saturated_q;

	// checks
	`ASSERT_IMPL(a_rsp_date_range, rsp_valid, (cur_month != 4'd0) && (cur_month <= 4'd12) && (cur_day != 5'd0), "result date out of range")
	`ASSERT_IMPL(a_rsp_flags_excl, rsp_valid, !(set_invalid && year_saturated), "both result flags set")
	`ASSERT_IMPL(a_idle_date_valid, state_q == gda_pkg::ST_IDLE, (day_q != '0) && (day_q <= len_fwd), "held date inconsistent")
	`ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid), $past(state_q) == gda_pkg::ST_DONE, "result published outside done")
	`ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted beat did not hold off the next")

endmodule

`default_nettype wire

>>> verif/gda_date_checker.sv
// shared test codes, date predictor and result scoreboard for the date add-days block
// depends on gda_pkg for the field types, YEAR_BITS and the reset date
`timescale 1ns / 1ps

package gda_tb_pkg;
	import gda_pkg::*;

	localparam logic FUNC_SET = 1'b0;
	localparam logic FUNC_ADD = 1'b1;
	localparam int   MONTHS   = 12;

	typedef struct packed {
		day_t   day;
		month_t month;
		year_t  year;
		logic   set_invalid;
		logic   year_saturated;
	} date_beat_t;

	// month length used by the set check: february is always 28 here
	function automatic int table_days(input int m);
		case (m)
			FEB:           return 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction
endpackage

module gda_date_checker
	import gda_pkg::*;
	import gda_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               func,
	input  logic [4:0]         new_day,
	input  logic [3:0]         new_month,
	input  logic [15:0]        new_year,
	input  logic signed [15:0] day_delta,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [4:0]         cur_day,
	input  logic [3:0]         cur_month,
	input  logic [15:0]        cur_year,
	input  logic               set_invalid,
	input  logic               year_saturated,
	output int                 mismatches,
	output int                 awaiting
);

	date_beat_t held_date;
	date_beat_t due_dates[$];
	date_beat_t want;
	date_beat_t seen;

	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % YEAR_MOD == 0);
	endfunction

	function automatic int month_span(input int m, input longint y);
		if (m == FEB && leap_year(y))
			return 29;
		return table_days(m);
	endfunction

	// next held date after one request beat, flags included
	function automatic date_beat_t apply_beat(input date_beat_t cur, input logic f,
			input day_t nd, input month_t nm, input logic [15:0] ny,
			input logic signed [15:0] dd);
		date_beat_t nxt;
		int         d;
		int         m;
		longint     y;
		longint     ytop;
		nxt = cur;
		nxt.set_invalid = 1'b0;
		nxt.year_saturated = 1'b0;
		ytop = (longint'(1) << YEAR_BITS) - 1;
		if (f == FUNC_SET) begin
			if (nm >= 1 && nm <= MONTHS && nd >= 1 && int'(nd) <= table_days(int'(nm))) begin
				nxt.day = nd;
				nxt.month = nm;
				nxt.year = year_t'(ny);
			end else begin
				nxt.day = day_t'(RESET_DAY);
				nxt.month = month_t'(RESET_MONTH);
				nxt.year = year_t'(RESET_YEAR);
				nxt.set_invalid = 1'b1;
			end
		end else if (dd != 0) begin
			d = int'(cur.day) + int'(dd);
			m = int'(cur.month);
			y = longint'(cur.year);
			if (m < 1 || m > MONTHS)
				m = 1;
			while (d > month_span(m, y)) begin
				d -= month_span(m, y);
				m++;
				if (m > MONTHS) begin
					if (y >= ytop) begin
						m = DEC;
						d = DEC_DAYS;
						nxt.year_saturated = 1'b1;
						break;
					end
					m = 1;
					y++;
				end
			end
			while (d < 1) begin
				if (m <= 1) begin
					if (y == 0) begin
						m = JAN;
						d = 1;
						nxt.year_saturated = 1'b1;
						break;
					end
					m = DEC;
					y--;
				end else begin
					m--;
				end
				d += month_span(m, y);
			end
			nxt.day = day_t'(d);
			nxt.month = month_t'(m);
			nxt.year = year_t'(y);
		end
		return nxt;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			held_date = {day_t'(RESET_DAY), month_t'(RESET_MONTH), year_t'(RESET_YEAR), 2'b00};
			due_dates.delete();
			mismatches = 0;
		end else begin
			if (req_valid && !req_stall) begin
				held_date = apply_beat(held_date, func, new_day, new_month, new_year, day_delta);
				due_dates.push_back(held_date);
			end
			if (rsp_valid && !rsp_stall) begin
				seen = {cur_day, cur_month, cur_year, set_invalid, year_saturated};
				if (due_dates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %0d.%0d.%0d inv %b sat %b",
							seen.day, seen.month, seen.year, seen.set_invalid,
							seen.year_saturated);
				end else begin
					want = due_dates.pop_front();
					if (seen.day !== want.day || seen.month !== want.month ||
							seen.year !== want.year || seen.set_invalid !== want.set_invalid ||
							seen.year_saturated !== want.year_saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("date mismatch: expected %0d.%0d.%0d inv %b sat %b, got %0d.%0d.%0d inv %b sat %b",
								want.day, want.month, want.year, want.set_invalid,
								want.year_saturated, seen.day, seen.month, seen.year,
								seen.set_invalid, seen.year_saturated);
					end
				end
			end
		end
		awaiting = due_dates.size();
	end

endmodule

>>> verif/tb_gregorian_date_add_days.sv
// top testbench for the gregorian date add-days block: clock, reset, beats and verdict
// depends on gda_pkg, gda_tb_pkg and gda_date_checker, instantiated next to the block
`timescale 1ns / 1ps

module tb_gregorian_date_add_days;
	import gda_pkg::*;
	import gda_tb_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_BEATS   = 515;
	// an add walks ~1080 months, a result may wait out the long receiver hold
	localparam int IDLE_LIMIT     = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int SQUEEZE_START  = 1500;
	localparam int SQUEEZE_CYCLES = 600;

	// receiver stall patterns, one picked per segment
	typedef enum int {
		PACE_FREE,
		PACE_COIN,
		PACE_HEAVY,
		PACE_PERIODIC
	} pace_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               func      = FUNC_SET;
	logic [4:0]         new_day   = '0;
	logic [3:0]         new_month = '0;
	logic [15:0]        new_year  = '0;
	logic signed [15:0] day_delta = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [4:0]         cur_day;
	logic [3:0]         cur_month;
	logic [15:0]        cur_year;
	logic               set_invalid;
	logic               year_saturated;

	int mismatches;
	int awaiting;
	// beats left in the current sender burst
	int burst_left = 1;

	always #HALF_PERIOD clk = ~clk;

	gregorian_date_add_days i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.func           (func),
		.new_day        (new_day),
		.new_month      (new_month),
		.new_year       (new_year),
		.day_delta      (day_delta),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.cur_day        (cur_day),
		.cur_month      (cur_month),
		.cur_year       (cur_year),
		.set_invalid    (set_invalid),
		.year_saturated (year_saturated)
	);

	// passive: predicts every accepted request beat and scores every result beat
	gda_date_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.func           (func),
		.new_day        (new_day),
		.new_month      (new_month),
		.new_year       (new_year),
		.day_delta      (day_delta),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.cur_day        (cur_day),
		.cur_month      (cur_month),
		.cur_year       (cur_year),
		.set_invalid    (set_invalid),
		.year_saturated (year_saturated),
		.mismatches     (mismatches),
		.awaiting       (awaiting)
	);

	// one request beat: drive at a rising edge, hold until taken, then maybe pause
	// valid stays high across back-to-back beats, so it is only ever set once per step
	task automatic offer(input logic f, input logic [4:0] nd, input logic [3:0] nm,
			input logic [15:0] ny, input logic signed [15:0] dd);
		int gap;
		req_valid <= 1'b1;
		func      <= f;
		new_day   <= nd;
		new_month <= nm;
		new_year  <= ny;
		day_delta <= dd;
		do @(posedge clk); while (req_stall);
		burst_left--;
		if (burst_left <= 0) begin
			// a quarter of the burst ends run straight into the next burst
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// set beat, unused delta field gets noise
	task automatic set_date(input int d, input int m, input int y);
		offer(FUNC_SET, 5'(d), 4'(m), 16'(y), 16'($urandom));
	endtask

	// add beat, unused date fields get noise
	task automatic add_days(input int dd);
		offer(FUNC_ADD, 5'($urandom), 4'($urandom), 16'($urandom), 16'(dd));
	endtask

	// random beat: mostly legal sets and adds, some malformed sets
	task automatic random_beat();
		int pick;
		int m;
		int y;
		int dd;
		pick = $urandom_range(0, 99);
		// year mix: calendar era, near zero, near the top, anything
		case ($urandom_range(0, 9))
			0:       y = $urandom_range(0, 3);
			1:       y = $urandom_range(65532, 65535);
			2:       y = $urandom_range(0, 65535);
			default: y = $urandom_range(1583, 2600);
		endcase
		if (pick < 26) begin
			m = $urandom_range(1, MONTHS);
			set_date($urandom_range(1, table_days(m)), m, y);
		end else if (pick < 30) begin
			// february 29/30 are always refused, else anything the fields hold
			if ($urandom_range(0, 1) == 1)
				set_date($urandom_range(29, 30), FEB, y);
			else
				set_date($urandom_range(0, 31), $urandom_range(0, 15), y);
		end else begin
			// small steps dominate to keep the month walk short
			case ($urandom_range(0, 19))
				0, 1, 2:       dd = int'($signed(16'($urandom)));
				3, 4, 5, 6, 7: dd = int'($urandom_range(0, 4000)) - 2000;
				8:             dd = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
				9:             dd = ($urandom_range(0, 1) == 1) ? 1 : -1;
				default:       dd = int'($urandom_range(0, 120)) - 60;
			endcase
			add_days(dd);
		end
	endtask

	// receiver: stall pattern changes per segment, plus one long hold that backs
	// the block up so its request side stalls while the sender keeps offering
	initial begin : rsp_pacer
		int    own_cycles;
		int    seg_left;
		bit    squeezed;
		pace_t pace;
		own_cycles = 0;
		seg_left   = 0;
		squeezed   = 1'b0;
		pace       = PACE_FREE;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			own_cycles++;
			if (!squeezed && own_cycles >= SQUEEZE_START) begin
				squeezed = 1'b1;
				rsp_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES - 1) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					pace = pace_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (pace)
					PACE_FREE:  rsp_stall <= 1'b0;
					PACE_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
					PACE_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
					default:    rsp_stall <= (own_cycles % 3 == 0);
				endcase
			end
		end
	end

	// watchdog: too long without any beat on either side ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** gregorian_date_add_days: FAILED **");
		$finish;
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero step leaves the reset date alone
		add_days(0);
		// lower year limit, small and full backward steps both pin at 1.1.0
		set_date(1, 1, 0);
		add_days(-1);
		add_days(-32768);
		// upper year limit, forward steps pin at 31.12 of the top year
		set_date(31, 12, 65535);
		add_days(1);
		add_days(32767);
		// leap rules: divisible by 4, century not leap, 400 leap
		set_date(28, 2, 2024);
		add_days(1);
		set_date(28, 2, 1900);
		add_days(1);
		set_date(28, 2, 2000);
		add_days(1);
		// backward into february uses the previous month's length
		set_date(1, 3, 2024);
		add_days(-1);
		// refused sets: feb 29, day zero, day past month end, month 0/13/15
		set_date(29, 2, 2024);
		set_date(0, 5, 2020);
		set_date(31, 4, 2020);
		set_date(15, 0, 2020);
		set_date(15, 13, 2020);
		set_date(31, 15, 65535);
		// longest legal walks in both directions
		set_date(31, 1, 2000);
		add_days(32767);
		add_days(-32768);
		add_days(-1);

		for (int n = 0; n < RANDOM_BEATS; n++)
			random_beat();
		req_valid <= 1'b0;

		// read the scoreboard away from the sampling edge
		@(negedge clk);
		while (awaiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("** gregorian_date_add_days: PASSED **");
		else
			$display("** gregorian_date_add_days: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/gda_pkg.sv
rtl/core/gda_alu.sv
rtl/core/gregorian_date_add_days.sv
verif/gda_date_checker.sv
verif/tb_gregorian_date_add_days.sv
